FILE: src/cbad_pkg.sv
// Package for the console bus address decoder: transaction types, target and
// command codes, memory map constants. No dependencies.
package cbad_pkg;

    localparam int RAM_ADDR_W = 11;
    localparam int RAM_DATA_W = 8;
    localparam int CLR_CNT_W  = RAM_ADDR_W + 1;

    typedef enum logic [1:0] {
        CMD_CPU_RD = 2'd0,
        CMD_CPU_WR = 2'd1,
        CMD_VID_RD = 2'd2,
        CMD_VID_WR = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        TGT_CPU_RAM   = 4'd0,
        TGT_VIDEO_REG = 4'd1,
        TGT_AUDIO     = 4'd2,
        TGT_PAD1      = 4'd3,
        TGT_PAD2      = 4'd4,
        TGT_STROBE    = 4'd5,
        TGT_DMA       = 4'd6,
        TGT_PRG       = 4'd7,
        TGT_CHR       = 4'd8,
        TGT_NAMETABLE = 4'd9,
        TGT_PALETTE   = 4'd10,
        TGT_NONE      = 4'd11
    } target_t;

    typedef enum logic [1:0] {
        MIR_SCREEN_LO = 2'd0,
        MIR_SCREEN_HI = 2'd1,
        MIR_VERTICAL  = 2'd2,
        MIR_HORIZ     = 2'd3
    } mirror_t;

    localparam logic [15:0] ADDR_VREG_BASE   = 16'h2000;
    localparam logic [15:0] ADDR_IO_BASE     = 16'h4000;
    localparam logic [15:0] ADDR_TEST_BASE   = 16'h4018;
    localparam logic [15:0] ADDR_PRG_BASE    = 16'h4020;
    localparam logic [15:0] ADDR_PAL_BASE    = 16'h3F00;
    localparam logic [15:0] ADDR_AUD_GAP0    = 16'h4009;
    localparam logic [15:0] ADDR_AUD_GAP1    = 16'h400D;
    localparam logic [15:0] ADDR_AUD_LAST    = 16'h4013;
    localparam logic [15:0] ADDR_DMA         = 16'h4014;
    localparam logic [15:0] ADDR_APU_STATUS  = 16'h4015;
    localparam logic [15:0] ADDR_PAD1        = 16'h4016;
    localparam logic [15:0] ADDR_PAD2        = 16'h4017;
    localparam logic [15:0] VREG_MASK        = 16'h2007;
    localparam logic [15:0] NT_MASK          = 16'h2FFF;
    localparam logic [15:0] PAL_MASK         = 16'h3F1F;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        target_t     target;
        logic [15:0] device_address;
        logic [7:0]  read_data;
        logic        fault;
    } rsp_t;

    typedef struct packed {
        target_t                 target;
        logic [15:0]             device_address;
        logic                    fault;
        logic                    wram_we;
        logic                    wram_re;
        logic                    nt_we;
        logic                    nt_re;
        logic [RAM_ADDR_W-1:0]   ram_addr;
    } dec_t;

endpackage

FILE: src/console_bus_address_decoder.sv
// Console bus address decoder: top level with work RAM, nametable RAM,
// clear sequencer and result register. Depends on cbad_pkg, cbad_decode, cbad_ram.
// Result: valid in the cycle after a transaction is accepted.
// Throughput: one transaction per cycle while req_stall is low; RAM reads
// use the registered RAM port. Reset: mirror_mode clears to 0; both RAMs are
// swept to zero (all 2048 addresses) after reset, while req_stall is high.
module console_bus_address_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  cbad_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cbad_pkg::rsp_t    rsp,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_data
);

    localparam int AW = cbad_pkg::RAM_ADDR_W;
    localparam int DW = cbad_pkg::RAM_DATA_W;

    cbad_pkg::dec_t                    dec;
    logic [1:0]                        mirror_reg;
    logic [cbad_pkg::CLR_CNT_W-1:0]    clr_cnt_reg;
    logic [cbad_pkg::CLR_CNT_W-1:0]    clr_cnt_next;
    logic                              clr_done;
    logic                              accept;
    logic                              advance;
    logic                              rsp_valid_reg;
    logic                              rsp_valid_next;
    cbad_pkg::target_t                 tgt_reg;
    logic [15:0]                       dev_reg;
    logic                              fault_reg;
    logic                              rd_wram_reg;
    logic                              rd_nt_reg;
    logic                              wram_we;
    logic                              wram_re;
    logic                              nt_we;
    logic                              nt_re;
    logic [AW-1:0]                     ram_addr;
    logic [DW-1:0]                     ram_wdata;
    logic [DW-1:0]                     wram_q;
    logic [DW-1:0]                     nt_q;

    assign clr_done  = clr_cnt_reg[cbad_pkg::CLR_CNT_W-1];
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !clr_done || !advance;
    assign accept    = req_valid && !req_stall;

    cbad_decode u_decode (
        .req         (req),
        .mirror_mode (mirror_reg),
        .dec         (dec)
    );

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        if (!clr_done)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = accept;
        end
        ram_addr  = clr_done ? dec.ram_addr : clr_cnt_reg[AW-1:0];
        ram_wdata = clr_done ? req.write_data : '0;
        wram_we   = !clr_done || (accept && dec.wram_we);
        nt_we     = !clr_done || (accept && dec.nt_we);
        wram_re   = accept && dec.wram_re;
        nt_re     = accept && dec.nt_re;
    end

    cbad_ram #(.ADDR_W(AW), .DATA_W(DW)) u_work_ram (
        .clk   (clk),
        .we    (wram_we),
        .re    (wram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (wram_q)
    );

    cbad_ram #(.ADDR_W(AW), .DATA_W(DW)) u_nt_ram (
        .clk   (clk),
        .we    (nt_we),
        .re    (nt_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (nt_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg    <= 2'b00;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                mirror_reg <= cfg_data;
            end
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tgt_reg     <= dec.target;
            dev_reg     <= dec.device_address;
            fault_reg   <= dec.fault;
            rd_wram_reg <= dec.wram_re;
            rd_nt_reg   <= dec.nt_re;
        end
    end

    assign rsp_valid          = rsp_valid_reg;
    assign rsp.target         = tgt_reg;
    assign rsp.device_address = dev_reg;
    assign rsp.fault          = fault_reg;
    assign rsp.read_data      = rd_wram_reg ? wram_q : (rd_nt_reg ? nt_q : '0);

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done |-> req_stall)
        else $error("transaction accepted during RAM clear");

    a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("accepted transaction produced no result");

    a_fault_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.fault |-> rsp.target == cbad_pkg::TGT_NONE)
        else $error("fault with a real target");

    a_rdata_src: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.read_data != '0 |->
        rsp.target == cbad_pkg::TGT_CPU_RAM || rsp.target == cbad_pkg::TGT_NAMETABLE)
        else $error("read data from a non-RAM target");

    a_ram_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.target == cbad_pkg::TGT_CPU_RAM ||
        rsp.target == cbad_pkg::TGT_NAMETABLE) |-> rsp.device_address[15:11] == 5'd0)
        else $error("RAM index out of range");

endmodule

FILE: src/cbad_ram.sv
// Generic single-port RAM, registered read data.
// No dependencies.
module cbad_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: src/cbad_decode.sv
// Memory map decode of one bus transaction, including nametable mirroring
// and palette aliasing. Depends on cbad_pkg.
module cbad_decode (
    input  cbad_pkg::req_t   req,
    input  logic [1:0]       mirror_mode,
    output cbad_pkg::dec_t   dec
);

    logic        video;
    logic        write;
    logic [15:0] a;
    logic        upper;
    logic        audio_wr;
    logic [15:0] pal;

    assign video = req.command[1];
    assign write = req.command[0];
    assign a     = req.address;

    always_comb
    begin
        case (cbad_pkg::mirror_t'(mirror_mode))
            cbad_pkg::MIR_SCREEN_LO: upper = 1'b0;
            cbad_pkg::MIR_SCREEN_HI: upper = 1'b1;
            cbad_pkg::MIR_VERTICAL:  upper = a[10];
            cbad_pkg::MIR_HORIZ:     upper = a[11];
            default:                 upper = 1'b0;
        endcase
    end

    assign audio_wr = (a <= cbad_pkg::ADDR_AUD_LAST && a != cbad_pkg::ADDR_AUD_GAP0 &&
                       a != cbad_pkg::ADDR_AUD_GAP1) ||
                      a == cbad_pkg::ADDR_APU_STATUS || a == cbad_pkg::ADDR_PAD2;

    // 0x3F10/14/18/1C fold onto 0x3F00/04/08/0C
    always_comb
    begin
        pal = a & cbad_pkg::PAL_MASK;
        if (pal[1:0] == 2'b00)
        begin
            pal[4] = 1'b0;
        end
    end

    always_comb
    begin
        dec.target         = cbad_pkg::TGT_NONE;
        dec.device_address = 16'h0000;
        dec.fault          = 1'b0;
        dec.wram_we        = 1'b0;
        dec.wram_re        = 1'b0;
        dec.nt_we          = 1'b0;
        dec.nt_re          = 1'b0;
        dec.ram_addr       = a[cbad_pkg::RAM_ADDR_W-1:0];
        if (!video)
        begin
            if (a < cbad_pkg::ADDR_VREG_BASE)
            begin
                dec.target         = cbad_pkg::TGT_CPU_RAM;
                dec.device_address = {5'b0, a[cbad_pkg::RAM_ADDR_W-1:0]};
                dec.wram_we        = write;
                dec.wram_re        = !write;
            end
            else if (a < cbad_pkg::ADDR_IO_BASE)
            begin
                dec.target         = cbad_pkg::TGT_VIDEO_REG;
                dec.device_address = a & cbad_pkg::VREG_MASK;
            end
            else if (a < cbad_pkg::ADDR_TEST_BASE)
            begin
                if (!write)
                begin
                    dec.device_address = a;
                    if (a == cbad_pkg::ADDR_APU_STATUS)
                    begin
                        dec.target = cbad_pkg::TGT_AUDIO;
                    end
                    else if (a == cbad_pkg::ADDR_PAD1)
                    begin
                        dec.target = cbad_pkg::TGT_PAD1;
                    end
                    else if (a == cbad_pkg::ADDR_PAD2)
                    begin
                        dec.target = cbad_pkg::TGT_PAD2;
                    end
                    else
                    begin
                        dec.device_address = 16'h0000;
                    end
                end
                else if (audio_wr)
                begin
                    dec.target         = cbad_pkg::TGT_AUDIO;
                    dec.device_address = a;
                end
                else if (a == cbad_pkg::ADDR_DMA)
                begin
                    dec.target         = cbad_pkg::TGT_DMA;
                    dec.device_address = {req.write_data, 8'h00};
                end
                else if (a == cbad_pkg::ADDR_PAD1)
                begin
                    dec.target         = cbad_pkg::TGT_STROBE;
                    dec.device_address = a;
                end
            end
            else if (a < cbad_pkg::ADDR_PRG_BASE)
            begin
                dec.fault = 1'b1;
            end
            else
            begin
                dec.target         = cbad_pkg::TGT_PRG;
                dec.device_address = a;
            end
        end
        else
        begin
            if (a < cbad_pkg::ADDR_VREG_BASE)
            begin
                dec.target         = cbad_pkg::TGT_CHR;
                dec.device_address = a;
            end
            else if (a < cbad_pkg::ADDR_PAL_BASE)
            begin
                dec.target         = cbad_pkg::TGT_NAMETABLE;
                dec.ram_addr       = {upper, a[9:0]};
                dec.device_address = {5'b0, upper, a[9:0]};
                dec.nt_we          = write;
                dec.nt_re          = !write;
            end
            else if (a < cbad_pkg::ADDR_IO_BASE)
            begin
                dec.target         = cbad_pkg::TGT_PALETTE;
                dec.device_address = pal;
            end
            else
            begin
                dec.fault = 1'b1;
            end
        end
    end

endmodule
